// ----- design/btm_pkg.sv -----
// btm_pkg: shared types, constants and the microcode program of the tempo meter
// used by btm_seq, btm_dp and beat_tempo_meter_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package btm_pkg;

    localparam int BPM_W   = 16;
    localparam int STEP_W  = 4;
    localparam int THR_W   = 8;
    localparam int PULSE_W = 10;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [BPM_W-1:0]   TEMPO_MAX    = 16'hFFFF;
    localparam logic [THR_W-1:0]   THR_RESET    = 8'd1;
    localparam logic [PULSE_W-1:0] PULSE_RESET  = 10'd50;
    localparam logic               REG_THRESHOLD = 1'b0;
    localparam logic               REG_PULSE     = 1'b1;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_BEAT  = 2'd1,
        REQ_RESET = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_TICK_INC,
        OP_LIT_CHECK,
        OP_BEAT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_TEMPO_QUO,
        OP_TEMPO_MAX,
        OP_MSTART,
        OP_POS_ADV,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NOT_START,
        C_IS_TICK,
        C_IS_BEAT,
        C_IS_UNKNOWN,
        C_NOT_LAST,
        C_NOT_VALID,
        C_IV_ZERO,
        C_DIV_MORE,
        C_OUT_BLOCKED
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // flags from the datapath that the sequencer branches on
    typedef struct packed {
        logic is_tick;
        logic is_beat;
        logic is_unknown;
        logic not_last;
        logic not_valid;
        logic iv_zero;
        logic div_more;
    } t_flags;

    typedef struct packed {
        logic             changed;
        logic             done;
        logic             lit;
        logic [1:0]       pos;
        logic [BPM_W-1:0] bpm;
    } t_result;

    localparam logic [STEP_W-1:0] ST_WAIT    = 4'd0;
    localparam logic [STEP_W-1:0] ST_CLEAR   = 4'd4;
    localparam logic [STEP_W-1:0] ST_TICK    = 4'd5;
    localparam logic [STEP_W-1:0] ST_BEAT    = 4'd7;
    localparam logic [STEP_W-1:0] ST_DIV     = 4'd10;
    localparam logic [STEP_W-1:0] ST_SAT     = 4'd12;
    localparam logic [STEP_W-1:0] ST_MSTART  = 4'd13;
    localparam logic [STEP_W-1:0] ST_POS_ADV = 4'd14;
    localparam logic [STEP_W-1:0] ST_EMIT    = 4'd15;

    // microcode: jump to target when cond holds, else fall through
    // (the emit step falls through to the wait step by counter wrap)
    function automatic t_uword btm_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            4'd0:  w = '{OP_NOP,        C_NOT_START,   ST_WAIT};
            4'd1:  w = '{OP_NOP,        C_IS_TICK,     ST_TICK};
            4'd2:  w = '{OP_NOP,        C_IS_BEAT,     ST_BEAT};
            4'd3:  w = '{OP_NOP,        C_IS_UNKNOWN,  ST_EMIT};
            4'd4:  w = '{OP_CLEAR,      C_ALWAYS,      ST_EMIT};
            4'd5:  w = '{OP_TICK_INC,   C_ALWAYS,      4'd6};
            4'd6:  w = '{OP_LIT_CHECK,  C_ALWAYS,      ST_EMIT};
            4'd7:  w = '{OP_BEAT,       C_NOT_LAST,    ST_POS_ADV};
            4'd8:  w = '{OP_NOP,        C_NOT_VALID,   ST_MSTART};
            4'd9:  w = '{OP_DIV_INIT,   C_IV_ZERO,     ST_SAT};
            4'd10: w = '{OP_DIV_STEP,   C_DIV_MORE,    ST_DIV};
            4'd11: w = '{OP_TEMPO_QUO,  C_ALWAYS,      ST_MSTART};
            4'd12: w = '{OP_TEMPO_MAX,  C_ALWAYS,      ST_MSTART};
            4'd13: w = '{OP_MSTART,     C_ALWAYS,      ST_POS_ADV};
            4'd14: w = '{OP_POS_ADV,    C_ALWAYS,      ST_EMIT};
            4'd15: w = '{OP_EMIT,       C_OUT_BLOCKED, ST_EMIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/beat_tempo_meter_unit.sv -----
// a tick steps time and checks the indicator, a reset clears, an unknown goes to emit;
// closing a measure runs clog2(60000*BEATS_PER_MEASURE+1) divider steps (18 at 4 beats)
// throughput: one item at a time; the next transfer is taken once the sequencer is
// back at its wait step, while the previous result may still sit in the output register
// the shared radix-2 divider sets the worst case; synchronous reset clears the control
// and time state, not the output data, and loads threshold 1, pulse 50
`timescale 1ns / 1ps
`default_nettype none

module beat_tempo_meter_unit #(
    parameter int BEATS_PER_MEASURE = 4,
    parameter int TIME_BITS         = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [15:0]                  s_axis_tdata,   // shown_bpm[15:0]
    input  wire logic [1:0]                   s_axis_tuser,   // req_type[1:0]
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // bpm[15:0], beat_position[17:16], indicator_on[18], measure_done[19],
    // changed[20], zero[23:21]
    output logic [23:0]                       m_axis_tdata,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [btm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [btm_pkg::APB_DW-1:0]   pwdata,
    output logic [btm_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    logic [btm_pkg::THR_W-1:0]   r_thr;
    logic [btm_pkg::PULSE_W-1:0] r_pulse;
    logic                        r_out_valid;
    btm_pkg::t_result            r_out;

    btm_pkg::t_op     op;
    btm_pkg::t_flags  flags;
    btm_pkg::t_result result;
    logic             idle;
    logic             in_xfer;
    logic             blocked;
    logic             emit;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == btm_pkg::REG_PULSE)
                   ? btm_pkg::APB_DW'(r_pulse) : btm_pkg::APB_DW'(r_thr);

    assign s_axis_tready = idle;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign blocked       = r_out_valid && !m_axis_tready;
    assign emit          = (op == btm_pkg::OP_EMIT) && !blocked;

    btm_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (s_axis_tvalid),
        .i_blocked (blocked),
        .i_flags   (flags),
        .o_op      (op),
        .o_idle    (idle)
    );

    btm_dp #(
        .BEATS_PER_MEASURE (BEATS_PER_MEASURE),
        .TIME_BITS         (TIME_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_load   (in_xfer),
        .i_req    (s_axis_tuser),
        .i_shown  (s_axis_tdata),
        .i_thr    (r_thr),
        .i_pulse  (r_pulse),
        .o_flags  (flags),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= btm_pkg::THR_RESET;
            r_pulse     <= btm_pkg::PULSE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == btm_pkg::REG_PULSE) begin
                    r_pulse <= pwdata[btm_pkg::PULSE_W-1:0];
                end else begin
                    r_thr <= pwdata[btm_pkg::THR_W-1:0];
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

    // sequencer leaves its wait step right after taking a transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("sequencer still idle after input transfer");

    // a result is held at the emit step until the output register frees up
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == btm_pkg::OP_EMIT && blocked) |=> (op == btm_pkg::OP_EMIT))
        else $error("emit step left while output was blocked");

    // an emitted result always shows up as valid output
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> m_axis_tvalid)
        else $error("emitted result not presented");

    // zero threshold forces the changed flag
    a_zero_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_thr == '0 && !cfg_wr) |=> m_axis_tdata[20])
        else $error("changed flag low with zero threshold");

endmodule

`default_nettype wire

// ----- design/btm_seq.sv -----
// btm_seq: step counter and microcode fetch with conditional jumps
// depends on btm_pkg (program table, op and condition codes)
`timescale 1ns / 1ps
`default_nettype none

module btm_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_blocked,
    input  wire btm_pkg::t_flags i_flags,
    output btm_pkg::t_op         o_op,
    output logic                 o_idle
);

    logic [btm_pkg::STEP_W-1:0] r_step;
    logic [btm_pkg::STEP_W-1:0] n_step;
    btm_pkg::t_uword            uw;
    logic                       take;

    assign uw = btm_pkg::btm_rom(r_step);

    always_comb begin
        unique case (uw.cond)
            btm_pkg::C_ALWAYS:      take = 1'b1;
            btm_pkg::C_NOT_START:   take = !i_start;
            btm_pkg::C_IS_TICK:     take = i_flags.is_tick;
            btm_pkg::C_IS_BEAT:     take = i_flags.is_beat;
            btm_pkg::C_IS_UNKNOWN:  take = i_flags.is_unknown;
            btm_pkg::C_NOT_LAST:    take = i_flags.not_last;
            btm_pkg::C_NOT_VALID:   take = i_flags.not_valid;
            btm_pkg::C_IV_ZERO:     take = i_flags.iv_zero;
            btm_pkg::C_DIV_MORE:    take = i_flags.div_more;
            btm_pkg::C_OUT_BLOCKED: take = i_blocked;
            default:                take = 1'b0;
        endcase
        n_step = take ? uw.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= btm_pkg::ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_op   = uw.op;
    assign o_idle = (r_step == btm_pkg::ST_WAIT);

endmodule

`default_nettype wire

// ----- design/btm_dp.sv -----
// btm_dp: tempo meter datapath: time and position state, shared radix-2 divider
// depends on btm_pkg; driven one operation per cycle by btm_seq
`timescale 1ns / 1ps
`default_nettype none

module btm_dp #(
    parameter int BEATS_PER_MEASURE = 4,
    parameter int TIME_BITS         = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire btm_pkg::t_op                  i_op,
    input  wire logic                          i_load,
    input  wire logic [1:0]                    i_req,
    input  wire logic [btm_pkg::BPM_W-1:0]     i_shown,
    input  wire logic [btm_pkg::THR_W-1:0]     i_thr,
    input  wire logic [btm_pkg::PULSE_W-1:0]   i_pulse,
    output btm_pkg::t_flags                    o_flags,
    output btm_pkg::t_result                   o_result
);

    localparam int NUMER_VAL = 60000 * BEATS_PER_MEASURE;
    localparam int NB        = $clog2(NUMER_VAL + 1);
    localparam int CB        = $clog2(NB);
    localparam int PW        = $clog2(BEATS_PER_MEASURE);
    localparam int PXW       = (PW < 2) ? 2 : PW;
    localparam int CW        = (NB + 1 > TIME_BITS) ? NB + 1 : TIME_BITS;
    localparam logic [NB-1:0] NUMER    = NB'(NUMER_VAL);
    localparam logic [PW-1:0] POS_LAST = PW'(BEATS_PER_MEASURE - 1);
    localparam logic [CB-1:0] CNT_INIT = CB'(NB - 1);

    logic [TIME_BITS-1:0]       r_ms;
    logic [TIME_BITS-1:0]       r_mstart;
    logic [TIME_BITS-1:0]       r_lit_since;
    logic [TIME_BITS-1:0]       r_iv;
    logic [PW-1:0]              r_pos;
    logic                       r_valid;
    logic                       r_lit;
    logic                       r_done;
    logic [btm_pkg::BPM_W-1:0]  r_tempo;
    logic [1:0]                 r_req;
    logic [btm_pkg::BPM_W-1:0]  r_shown;
    logic [NB-1:0]              r_rem;
    logic [NB-1:0]              r_quo;
    logic [CB-1:0]              r_cnt;

    logic [CW-1:0]              trial;
    logic [CW-1:0]              iv_x;
    logic                       fits;
    logic [TIME_BITS-1:0]       lit_age;
    logic [btm_pkg::BPM_W-1:0]  diff;
    logic [PXW-1:0]             pos_x;

    // one restoring division step: bring down the next numerator bit
    assign trial   = CW'({r_rem, NUMER[r_cnt]});
    assign iv_x    = CW'(r_iv);
    assign fits    = (trial >= iv_x);
    assign lit_age = r_ms - r_lit_since;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms        <= '0;
            r_mstart    <= '0;
            r_lit_since <= '0;
            r_pos       <= '0;
            r_valid     <= 1'b0;
            r_lit       <= 1'b0;
            r_done      <= 1'b0;
            r_tempo     <= '0;
            r_req       <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_load) begin
                r_req   <= i_req;
                r_shown <= i_shown;
                r_done  <= 1'b0;
            end
            case (i_op)
                btm_pkg::OP_CLEAR: begin
                    r_pos       <= '0;
                    r_mstart    <= '0;
                    r_valid     <= 1'b0;
                    r_lit_since <= '0;
                    r_lit       <= 1'b0;
                end
                btm_pkg::OP_TICK_INC: r_ms <= r_ms + 1'b1;
                btm_pkg::OP_LIT_CHECK: begin
                    if (r_lit && lit_age >= TIME_BITS'(i_pulse)) begin
                        r_lit <= 1'b0;
                    end
                end
                btm_pkg::OP_BEAT: begin
                    r_lit_since <= r_ms;
                    r_lit       <= 1'b1;
                    r_iv        <= r_ms - r_mstart;
                end
                btm_pkg::OP_DIV_INIT: begin
                    r_cnt <= CNT_INIT;
                    r_rem <= '0;
                    r_quo <= '0;
                end
                btm_pkg::OP_DIV_STEP: begin
                    r_rem <= fits ? NB'(trial - iv_x) : NB'(trial);
                    r_quo <= {r_quo[NB-2:0], fits};
                    r_cnt <= r_cnt - 1'b1;
                end
                btm_pkg::OP_TEMPO_QUO: begin
                    r_tempo <= (r_quo > NB'(btm_pkg::TEMPO_MAX)) ? btm_pkg::TEMPO_MAX
                                                                 : r_quo[btm_pkg::BPM_W-1:0];
                    r_done  <= 1'b1;
                end
                btm_pkg::OP_TEMPO_MAX: begin
                    r_tempo <= btm_pkg::TEMPO_MAX;
                    r_done  <= 1'b1;
                end
                btm_pkg::OP_MSTART: begin
                    r_mstart <= r_ms;
                    r_valid  <= 1'b1;
                end
                btm_pkg::OP_POS_ADV: r_pos <= (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
                default: ;
            endcase
        end
    end

    assign o_flags.is_tick    = (r_req == btm_pkg::REQ_TICK);
    assign o_flags.is_beat    = (r_req == btm_pkg::REQ_BEAT);
    assign o_flags.is_unknown = (r_req == btm_pkg::REQ_NONE);
    assign o_flags.not_last   = (r_pos != POS_LAST);
    assign o_flags.not_valid  = !r_valid;
    assign o_flags.iv_zero    = (r_iv == '0);
    assign o_flags.div_more   = (r_cnt != '0);

    assign diff  = (r_tempo >= r_shown) ? r_tempo - r_shown : r_shown - r_tempo;
    assign pos_x = PXW'(r_pos);

    assign o_result.changed = (diff >= btm_pkg::BPM_W'(i_thr));
    assign o_result.done    = r_done;
    assign o_result.lit     = r_lit;
    assign o_result.pos     = pos_x[1:0];
    assign o_result.bpm     = r_tempo;

endmodule

`default_nettype wire
